// File: sv/nts_pkg.sv
// Shared types, constants and the notch rate table of the notch throttle speed integrator.
`default_nettype none

package nts_pkg;

  // Default values of the top level parameters.
  localparam int unsigned TOP_SPEED_DEF  = 10000;
  localparam int unsigned FLOOR_STEP_DEF = 100;

  // Fixed constants of the throttle.
  localparam int unsigned FLOOR_RESET  = 1000;
  localparam int unsigned DUTY_FULL    = 10000;
  localparam int unsigned RATE_MAX_MAG = 1000;
  localparam int unsigned RATE_W       = 11;

  // Request kinds.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_KNOB = 1'b1;

  // Notch codes, power side first.
  localparam logic [3:0] NOTCH_P5 = 4'd0;
  localparam logic [3:0] NOTCH_P4 = 4'd1;
  localparam logic [3:0] NOTCH_P3 = 4'd2;
  localparam logic [3:0] NOTCH_P2 = 4'd3;
  localparam logic [3:0] NOTCH_P1 = 4'd4;
  localparam logic [3:0] NOTCH_N  = 4'd5;
  localparam logic [3:0] NOTCH_B1 = 4'd6;
  localparam logic [3:0] NOTCH_B2 = 4'd7;
  localparam logic [3:0] NOTCH_B3 = 4'd8;
  localparam logic [3:0] NOTCH_B4 = 4'd9;
  localparam logic [3:0] NOTCH_B5 = 4'd10;
  localparam logic [3:0] NOTCH_EB = 4'd11;

  // Motor modes.
  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_REV  = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [3:0] notch;
    logic       forward;
    logic       knob_dir;
  } in_t;

  typedef struct packed {
    logic [13:0] speed_now;
    logic        accelerating;
    logic        braking;
    logic [1:0]  motor_mode;
    logic [13:0] pwm_duty;
    logic [12:0] floor_now;
  } out_t;

  function automatic logic signed [RATE_W-1:0] notch_rate(input logic [3:0] notch);
    logic signed [RATE_W-1:0] rate;
    case (notch)
      NOTCH_P5: rate = 11'sd16;
      NOTCH_P4: rate = 11'sd8;
      NOTCH_P3: rate = 11'sd4;
      NOTCH_P2: rate = 11'sd2;
      NOTCH_P1: rate = 11'sd1;
      NOTCH_N:  rate = 11'sd0;
      NOTCH_B1: rate = -11'sd1;
      NOTCH_B2: rate = -11'sd2;
      NOTCH_B3: rate = -11'sd4;
      NOTCH_B4: rate = -11'sd8;
      NOTCH_B5: rate = -11'sd16;
      NOTCH_EB: rate = -11'sd1000;
      default:  rate = 11'sd0;
    endcase
    return rate;
  endfunction

endpackage

`default_nettype wire

// File: sv/nts_core.sv
// State update of speed, floor, direction and flags, with the first result stage.
`default_nettype none

module nts_core #(
  parameter int unsigned TOP_SPEED  = nts_pkg::TOP_SPEED_DEF,
  parameter int unsigned FLOOR_STEP = nts_pkg::FLOOR_STEP_DEF,
  parameter int unsigned SW         = $clog2(TOP_SPEED + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire nts_pkg::in_t  in_data,
  output      logic          a_valid,
  input  wire logic          a_ready,
  output      nts_pkg::out_t a_res,
  output      logic [SW-1:0] a_speed
);
  import nts_pkg::*;

  localparam int unsigned HALF_SPEED = TOP_SPEED / 2;
  localparam int unsigned FLOOR_MAX  = (HALF_SPEED > FLOOR_RESET) ? HALF_SPEED : FLOOR_RESET;
  localparam int unsigned FW         = $clog2(FLOOR_MAX + 1);
  localparam int unsigned AW         =
    $clog2(TOP_SPEED + FLOOR_MAX + FLOOR_STEP + RATE_MAX_MAG + 1) + 1;

  localparam logic signed [AW-1:0] TopS  = AW'(TOP_SPEED);
  localparam logic signed [AW-1:0] HalfS = AW'(HALF_SPEED);
  localparam logic signed [AW-1:0] StepS = AW'(FLOOR_STEP);
  localparam logic signed [AW-1:0] ZeroS = '0;

  logic [SW-1:0] speed;
  logic [FW-1:0] floor_lvl;
  logic          dir;
  logic          accel;
  logic          brake;

  logic [SW-1:0] speed_next;
  logic [FW-1:0] floor_next;
  logic          dir_next;
  logic          accel_next;
  logic          brake_next;

  logic                     accept;
  logic signed [RATE_W-1:0] rate;
  logic signed [AW-1:0]     speed_s;
  logic signed [AW-1:0]     floor_s;
  logic signed [AW-1:0]     sum_s;
  logic signed [AW-1:0]     low_s;
  logic signed [AW-1:0]     clip_s;
  logic signed [AW-1:0]     f_sum;
  logic signed [AW-1:0]     f_low;
  logic signed [AW-1:0]     f_clip;
  logic [1:0]               mode_next;

  assign in_ready = !a_valid || a_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rate    = notch_rate(in_data.notch);
    speed_s = $signed(AW'(speed));
    floor_s = $signed(AW'(floor_lvl));

    // Tick: add the rate, then hold the speed between the floor and top speed.
    sum_s  = speed_s + AW'(rate);
    low_s  = (sum_s < floor_s) ? floor_s : sum_s;
    clip_s = (low_s > TopS) ? TopS : low_s;

    // Knob: step the floor and keep it within zero and half of top speed.
    f_sum  = in_data.knob_dir ? (floor_s + StepS) : (floor_s - StepS);
    f_low  = (f_sum < ZeroS) ? ZeroS : f_sum;
    f_clip = (f_low > HalfS) ? HalfS : f_low;

    speed_next = speed;
    floor_next = floor_lvl;
    dir_next   = dir;
    accel_next = accel;
    brake_next = brake;
    if (in_data.req_type == REQ_KNOB) begin
      floor_next = FW'(f_clip);
    end else begin
      speed_next = SW'(clip_s);
      dir_next   = in_data.forward;
      accel_next = rate > 0;
      brake_next = rate < 0;
    end

    if (speed_next == '0) begin
      mode_next = MODE_STOP;
    end else if (dir_next) begin
      mode_next = MODE_FWD;
    end else begin
      mode_next = MODE_REV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= '0;
      floor_lvl <= FW'(FLOOR_RESET);
      dir       <= 1'b0;
      accel     <= 1'b0;
      brake     <= 1'b0;
      a_valid   <= 1'b0;
    end else begin
      if (accept) begin
        speed     <= speed_next;
        floor_lvl <= floor_next;
        dir       <= dir_next;
        accel     <= accel_next;
        brake     <= brake_next;
        a_valid   <= 1'b1;
      end else if (a_ready) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_speed            <= speed_next;
      a_res.speed_now    <= 14'(speed_next);
      a_res.accelerating <= accel_next;
      a_res.braking      <= brake_next;
      a_res.motor_mode   <= mode_next;
      a_res.pwm_duty     <= '0;
      a_res.floor_now    <= 13'(floor_next);
    end
  end

endmodule

`default_nettype wire

// File: sv/nts_duty.sv
// Output stage that scales the speed to a PWM duty by a constant reciprocal multiply.
`default_nettype none

module nts_duty #(
  parameter int unsigned TOP_SPEED = nts_pkg::TOP_SPEED_DEF,
  parameter int unsigned SW        = $clog2(TOP_SPEED + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          a_valid,
  output      logic          a_ready,
  input  wire nts_pkg::out_t a_res,
  input  wire logic [SW-1:0] a_speed,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      nts_pkg::out_t out_data
);
  import nts_pkg::*;

  // With a shift of twice the speed width, the rounded-up reciprocal gives the
  // truncated quotient exactly for every speed up to top speed.
  localparam int unsigned  K   = 2 * SW;
  localparam logic [63:0]  Mul = ((64'(DUTY_FULL) << K) / 64'(TOP_SPEED)) + 64'd1;
  localparam int unsigned  MW  = $clog2(Mul + 64'd1);
  localparam int unsigned  PW  = SW + MW;

  logic [PW-1:0] prod;
  logic          take;
  out_t          res_next;

  assign a_ready = !out_valid || out_ready;
  assign take    = a_valid && a_ready;
  assign prod    = PW'(a_speed) * PW'(Mul[MW-1:0]);

  always_comb begin
    res_next          = a_res;
    res_next.pwm_duty = 14'(prod >> K);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/notch_throttle_speed_integrator.sv
// Top level of the notch throttle speed integrator.
//
// One request on the input channel is either a control tick (notch and direction)
// or a knob event (floor up or down). Every request gives exactly one result with
// the speed, the accel and brake flags, the motor mode, the PWM duty and the floor.
// Both channels use valid and ready; a request is taken when in_valid and in_ready
// are high at a rising edge, a result when out_valid and out_ready are.
// The speed and floor state updates in the cycle a request is taken, so requests
// may follow one another in every cycle while the results move on. A request passes
// two register stages: the notch rate add and clamps at the edge that takes it, then
// the constant-reciprocal multiply that scales the speed to the duty when the second
// stage takes the result from the first; out_valid rises with that second stage.
// Sustained throughput is one request per cycle. When the receiver stalls, the two
// result stages fill and in_ready follows out_ready; nothing is dropped.
// Reset (rst, synchronous) sets speed zero, floor 1000, reverse direction, clears
// both flags and empties the result stages.
`default_nettype none

module notch_throttle_speed_integrator #(
  parameter int unsigned TOP_SPEED  = nts_pkg::TOP_SPEED_DEF,
  parameter int unsigned FLOOR_STEP = nts_pkg::FLOOR_STEP_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire nts_pkg::in_t  in_data,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      nts_pkg::out_t out_data
);
  import nts_pkg::*;

  localparam int unsigned SW = $clog2(TOP_SPEED + 1);

  logic          a_valid;
  logic          a_ready;
  out_t          a_res;
  logic [SW-1:0] a_speed;

  nts_core #(
    .TOP_SPEED  (TOP_SPEED),
    .FLOOR_STEP (FLOOR_STEP),
    .SW         (SW)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .a_valid  (a_valid),
    .a_ready  (a_ready),
    .a_res    (a_res),
    .a_speed  (a_speed)
  );

  nts_duty #(
    .TOP_SPEED (TOP_SPEED),
    .SW        (SW)
  ) u_duty (
    .clk       (clk),
    .rst       (rst),
    .a_valid   (a_valid),
    .a_ready   (a_ready),
    .a_res     (a_res),
    .a_speed   (a_speed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.pwm_duty <= 14'(DUTY_FULL)))
    else $error("pwm duty above full scale");

  // A stopped motor has zero duty.
  a_stop_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.motor_mode == MODE_STOP) |-> (out_data.pwm_duty == '0))
    else $error("nonzero duty while stopped");

  // One rate cannot both accelerate and brake.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.accelerating && out_data.braking))
    else $error("accel and brake flags both set");

  // With the first stage holding a result that cannot move on, no request is taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_ready) |-> !in_ready)
    else $error("request taken over a stalled result");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the notch throttle speed integrator with a per-request speed model.
`timescale 1ns / 100ps

module testbench;
  import nts_pkg::*;

  localparam int TOP_SPEED    = TOP_SPEED_DEF;
  localparam int FLOOR_STEP   = FLOOR_STEP_DEF;
  localparam int LATENCY      = 2;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_ITEMS   = 200;
  localparam int MAX_REPORTS  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Throttle state as predicted from the accepted requests.
  int   model_speed = 0;
  int   model_floor = FLOOR_RESET;
  logic model_dir   = 1'b0;
  logic model_accel = 1'b0;
  logic model_brake = 1'b0;

  out_t pending_status[$];
  out_t oldest_status;
  int   mismatches = 0;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  int   stall_requests = 0;
  int   stalls_done = 0;

  notch_throttle_speed_integrator dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int rate_of_notch(logic [3:0] notch);
    case (notch)
      NOTCH_P5: return 16;
      NOTCH_P4: return 8;
      NOTCH_P3: return 4;
      NOTCH_P2: return 2;
      NOTCH_P1: return 1;
      NOTCH_N:  return 0;
      NOTCH_B1: return -1;
      NOTCH_B2: return -2;
      NOTCH_B3: return -4;
      NOTCH_B4: return -8;
      NOTCH_B5: return -16;
      NOTCH_EB: return -1000;
      default:  return 0;
    endcase
  endfunction

  // Advances the throttle state by one request and returns the status it reports.
  function automatic out_t predict_status(in_t req);
    out_t status;
    int   rate;
    int   next_val;
    if (req.req_type == REQ_KNOB) begin
      next_val = req.knob_dir ? model_floor + FLOOR_STEP : model_floor - FLOOR_STEP;
      if (next_val < 0) next_val = 0;
      if (next_val > TOP_SPEED / 2) next_val = TOP_SPEED / 2;
      model_floor = next_val;
    end else begin
      rate = rate_of_notch(req.notch);
      model_accel = rate > 0;
      model_brake = rate < 0;
      next_val = model_speed + rate;
      if (next_val < model_floor) next_val = model_floor;
      if (next_val > TOP_SPEED) next_val = TOP_SPEED;
      model_speed = next_val;
      model_dir = req.forward;
    end
    status.speed_now    = model_speed[13:0];
    status.accelerating = model_accel;
    status.braking      = model_brake;
    if (model_speed == 0) begin
      status.motor_mode = MODE_STOP;
      status.pwm_duty   = '0;
    end else begin
      status.motor_mode = model_dir ? MODE_FWD : MODE_REV;
      status.pwm_duty   = 14'((model_speed * DUTY_FULL) / TOP_SPEED);
    end
    status.floor_now = model_floor[12:0];
    return status;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Results are checked before the request taken at the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_status.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: expected nothing, actual %p", $time, out_data);
        end else begin
          oldest_status = pending_status.pop_front();
          check_field("speed_now", oldest_status.speed_now, out_data.speed_now);
          check_field("accelerating", oldest_status.accelerating, out_data.accelerating);
          check_field("braking", oldest_status.braking, out_data.braking);
          check_field("motor_mode", oldest_status.motor_mode, out_data.motor_mode);
          check_field("pwm_duty", oldest_status.pwm_duty, out_data.pwm_duty);
          check_field("floor_now", oldest_status.floor_now, out_data.floor_now);
        end
      end
      if (in_valid && in_ready)
        pending_status.push_back(predict_status(in_data));
    end
  end

  // Receiver: random ready bursts, plus a long hold-off whenever one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_done != stall_requests) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES - 1) @(posedge clk);
        stalls_done = stall_requests;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input in_t req);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick(input logic [3:0] notch, input logic fwd);
    in_t req;
    req.req_type = REQ_TICK;
    req.notch    = notch;
    req.forward  = fwd;
    req.knob_dir = 1'($urandom);
    send_request(req);
  endtask

  task automatic send_knob(input logic cw);
    in_t req;
    req.req_type = REQ_KNOB;
    req.notch    = 4'($urandom);
    req.forward  = 1'($urandom);
    req.knob_dir = cw;
    send_request(req);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  // Every notch code including the unknown ones, then a knob step each way.
  task automatic test_every_notch();
    for (int n = 0; n < 16; n++)
      send_tick(4'(n), 1'(n));
    send_knob(1'b1);
    send_tick(NOTCH_N, 1'b1);
    send_knob(1'b0);
    send_tick(NOTCH_B5, 1'b0);
    wait_until_drained();
  endtask

  // Floor down to zero, speed down to a stop, floor up to its top, speed up to its top, then brake to the floor.
  task automatic test_speed_limits();
    repeat (12) send_knob(1'b0);
    repeat (12) send_tick(NOTCH_EB, 1'($urandom));
    send_tick(NOTCH_P1, 1'b1);
    send_tick(NOTCH_P1, 1'b0);
    send_tick(NOTCH_B2, 1'b1);
    repeat (52) send_knob(1'b1);
    send_tick(NOTCH_N, 1'b1);
    repeat (330) send_tick(NOTCH_P5, ($urandom_range(0, 9) != 0));
    repeat (5) send_knob(1'b0);
    repeat (8) send_tick(NOTCH_EB, 1'b1);
    repeat (30) send_knob(1'b0);
    wait_until_drained();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    stall_requests++;
    repeat (40) send_tick(4'($urandom_range(NOTCH_P5, NOTCH_P1)), 1'b1);
    repeat (10) send_knob(1'($urandom));
    wait_until_drained();
  endtask

  task automatic test_random_traffic();
    int   sent = 0;
    int   run_len;
    logic fwd;
    logic cw;
    in_t  req;
    while (sent < RANDOM_ITEMS) begin
      run_len = $urandom_range(1, 60);
      fwd = 1'($urandom);
      cw  = 1'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < run_len; i++)
            send_tick(4'($urandom_range(NOTCH_P5, NOTCH_P1)),
                      ($urandom_range(0, 15) == 0) ? ~fwd : fwd);
        end
        4, 5: begin
          for (int i = 0; i < run_len / 2 + 1; i++)
            send_tick(($urandom_range(0, 9) == 0) ? NOTCH_EB :
                      4'($urandom_range(NOTCH_B1, NOTCH_B5)), fwd);
        end
        6, 7: begin
          for (int i = 0; i < run_len / 4 + 1; i++)
            send_knob(($urandom_range(0, 5) == 0) ? ~cw : cw);
        end
        8: begin
          for (int i = 0; i < run_len / 4 + 1; i++)
            send_tick(($urandom_range(0, 1) == 0) ? NOTCH_N : 4'($urandom_range(12, 15)), fwd);
        end
        default: begin
          for (int i = 0; i < run_len / 6 + 1; i++) begin
            req = in_t'(7'($urandom));
            send_request(req);
          end
        end
      endcase
      sent += run_len;
      if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 60)
        wait_until_drained();
      if (sent >= RANDOM_ITEMS - CALM_ITEMS)
        idle_on = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_notch();
    test_speed_limits();
    test_backpressure();
    test_random_traffic();
    wait_until_drained();
    repeat (LATENCY + 8) @(posedge clk);
    if (pending_status.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d results never arrived", $time, pending_status.size());
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
